>>> rtl/zero_run_length_encoder_macros.svh
// Assertion macros shared by the zero run-length encoder RTL.
// Depends on nothing; the macros expect signals named clk and rst_n in scope.
`ifndef ZERO_RUN_LENGTH_ENCODER_MACROS_SVH
`define ZERO_RUN_LENGTH_ENCODER_MACROS_SVH
`ifndef SYNTH
`define ZRLE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ZRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ZRLE_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ZRLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/zrle_pkg.sv
// Shared types and constants for the zero run-length encoder.
// Depends on nothing; used by every module of the encoder.
`default_nettype none

package zrle_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0]  RUN_LIMIT = 8'd255;
    localparam logic [16:0] SIZE_CAP  = 17'h10000;

    // One classified pixel: an optional marker and run-length pair, then an
    // optional literal byte.
    typedef struct packed {
        logic        has_pair;
        logic [7:0]  run_len;
        logic        has_lit;
        logic [7:0]  lit;
        logic        image_end;
        logic [15:0] total;
        logic        ovf;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_FIRST,
        BK_RUN,
        BK_LIT
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/zrle_front.sv
// Front end of the zero run-length encoder: configuration, pixel intake and
// classification into queue commands. Depends on zrle_pkg.
`default_nettype none

module zrle_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [zrle_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [zrle_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [7:0]                          pixel,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output zrle_pkg::cmd_t                           q_cmd
);

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] count_reg;
    logic [31:0] cfg_product;
    logic [7:0]  zrun_reg;
    logic [7:0]  zrun_next;
    logic [31:0] pos_reg;
    logic [31:0] pos_next;
    logic [16:0] bytes_reg;
    logic [16:0] bytes_next;

    logic        fire;
    logic        image_empty;
    logic        last;
    logic [7:0]  zrun_inc;
    logic        run_full;
    logic [7:0]  zrun_after;
    logic [16:0] bytes_sum;
    logic [16:0] bytes_sat;

    assign cfg_product = (cfg_index == zrle_pkg::CFG_IMAGE_WIDTH)
                         ? 32'(cfg_wdata) * 32'(height_reg)
                         : 32'(width_reg) * 32'(cfg_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == zrle_pkg::CFG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_wdata;
            end
            else
            begin
                height_reg <= cfg_wdata;
            end
            count_reg <= cfg_product;
        end
    end

    assign in_stall    = q_full;
    assign fire        = in_valid && !q_full;
    assign image_empty = (count_reg == 32'd0);
    assign last        = ({1'b0, pos_reg} + 33'd1) >= {1'b0, count_reg};
    assign zrun_inc    = zrun_reg + 8'd1;
    assign run_full    = (zrun_inc == zrle_pkg::RUN_LIMIT);

    always_comb
    begin
        q_cmd.lit       = pixel;
        q_cmd.image_end = last;
        if (pixel != 8'd0)
        begin
            q_cmd.has_pair = (zrun_reg != 8'd0);
            q_cmd.run_len  = zrun_reg;
            q_cmd.has_lit  = 1'b1;
            zrun_after     = 8'd0;
        end
        else
        begin
            q_cmd.has_pair = run_full || last;
            q_cmd.run_len  = zrun_inc;
            q_cmd.has_lit  = 1'b0;
            zrun_after     = run_full ? 8'd0 : zrun_inc;
        end
        bytes_sum = bytes_reg + 17'({q_cmd.has_pair, q_cmd.has_lit});
        bytes_sat = (bytes_sum >= zrle_pkg::SIZE_CAP) ? zrle_pkg::SIZE_CAP : bytes_sum;
        q_cmd.total = bytes_sat[16] ? 16'hFFFF : bytes_sat[15:0];
        q_cmd.ovf   = bytes_sat[16];
    end

    assign q_push = fire && !image_empty && (q_cmd.has_pair || q_cmd.has_lit);

    always_comb
    begin
        zrun_next  = zrun_reg;
        pos_next   = pos_reg;
        bytes_next = bytes_reg;
        if (fire && !image_empty)
        begin
            if (last)
            begin
                zrun_next  = 8'd0;
                pos_next   = 32'd0;
                bytes_next = 17'd0;
            end
            else
            begin
                zrun_next  = zrun_after;
                pos_next   = pos_reg + 32'd1;
                bytes_next = bytes_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zrun_reg  <= '0;
            pos_reg   <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            zrun_reg  <= zrun_next;
            pos_reg   <= pos_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/zrle_queue.sv
// Short command queue between the front and back ends of the encoder.
// Depends on zrle_pkg for the command type.
`default_nettype none

module zrle_queue #(
    parameter int DEPTH = zrle_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  zrle_pkg::cmd_t      push_cmd,
    input  wire logic           pop,
    output zrle_pkg::cmd_t      head,
    output logic                not_empty,
    output logic                full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    zrle_pkg::cmd_t entries [DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;

    assign head      = entries[rd_ptr_reg];
    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == CW'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/zrle_back.sv
// Back end of the encoder: expands queued commands into output bytes and
// holds them in the output register. Depends on zrle_pkg.
`default_nettype none

module zrle_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  zrle_pkg::cmd_t      head,
    input  wire logic           head_valid,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                burst_end,
    output logic                image_end,
    output logic [15:0]         total_size,
    output logic                size_overflow
);

    zrle_pkg::back_state_t state_reg;
    zrle_pkg::back_state_t state_next;

    logic        advance;
    logic [7:0]  byte_sel;
    logic        is_last;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        burst_end_reg;
    logic        image_end_reg;
    logic [15:0] total_size_reg;
    logic        size_overflow_reg;

    assign advance = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        unique case (state_reg)
            zrle_pkg::BK_FIRST:
            begin
                byte_sel = head.has_pair ? 8'd0 : head.lit;
                is_last  = !head.has_pair;
            end
            zrle_pkg::BK_RUN:
            begin
                byte_sel = head.run_len;
                is_last  = !head.has_lit;
            end
            zrle_pkg::BK_LIT:
            begin
                byte_sel = head.lit;
                is_last  = 1'b1;
            end
            default:
            begin
                byte_sel = head.lit;
                is_last  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            unique case (state_reg)
                zrle_pkg::BK_FIRST:
                    state_next = head.has_pair ? zrle_pkg::BK_RUN : zrle_pkg::BK_FIRST;
                zrle_pkg::BK_RUN:
                    state_next = head.has_lit ? zrle_pkg::BK_LIT : zrle_pkg::BK_FIRST;
                default:
                    state_next = zrle_pkg::BK_FIRST;
            endcase
        end
    end

    assign pop = advance && is_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zrle_pkg::BK_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg      <= byte_sel;
            burst_end_reg     <= is_last;
            image_end_reg     <= is_last && head.image_end;
            total_size_reg    <= (is_last && head.image_end) ? head.total : 16'd0;
            size_overflow_reg <= is_last && head.image_end && head.ovf;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign burst_end     = burst_end_reg;
    assign image_end     = image_end_reg;
    assign total_size    = total_size_reg;
    assign size_overflow = size_overflow_reg;

endmodule

`default_nettype wire

>>> rtl/zero_run_length_encoder.sv
// Zero run-length encoder: a pixel's command is registered in the queue, then its first
// output byte in the output register; a pixel yields 0 to 3 bytes, one per unstalled cycle.
// Pixels are taken every cycle while the command queue has room; the single output
// byte port sets the sustained rate. Reset is asynchronous, active low: it clears the
// image size registers, the run, position and byte counters, the queue and the output.
// Depends on zrle_pkg, zrle_front, zrle_queue, zrle_back and the assertion macro header.
`default_nettype none

`include "zero_run_length_encoder_macros.svh"

module zero_run_length_encoder #(
    parameter int QUEUE_DEPTH = zrle_pkg::QUEUE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [zrle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [zrle_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       pixel,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            out_byte,
    output logic                                  burst_end,
    output logic                                  image_end,
    output logic [15:0]                           total_size,
    output logic                                  size_overflow
);

    zrle_pkg::cmd_t q_cmd;
    zrle_pkg::cmd_t q_head;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    logic           q_full;

    zrle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    zrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    zrle_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .head_valid    (q_not_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .burst_end     (burst_end),
        .image_end     (image_end),
        .total_size    (total_size),
        .size_overflow (size_overflow)
    );

    `ZRLE_ASSERT_IMPLIES(a_end_closes_burst, out_valid && image_end, burst_end, "image end without burst end")
    `ZRLE_ASSERT_IMPLIES(a_ovf_saturates, out_valid && size_overflow, image_end && (total_size == 16'hFFFF), "overflow without saturated size")
    `ZRLE_ASSERT_IMPLIES(a_size_only_at_end, out_valid && !image_end, (total_size == 16'd0) && !size_overflow, "size shown before image end")
    `ZRLE_ASSERT_NEXT(a_queue_no_overrun, q_full && !q_pop, !q_push, "push into a full queue")

endmodule

`default_nettype wire

>>> tb/zero_run_length_encoder_test.sv
// Self-checking testbench for zero_run_length_encoder: pixels go in and bytes come out over
// valid/stall channels, and a scoreboard predicts every byte. Depends on zrle_pkg and the
// encoder RTL.

typedef struct packed {
    logic [7:0]  out_byte;
    logic        burst_end;
    logic        image_end;
    logic [15:0] total_size;
    logic        size_overflow;
} byte_rec_t;

class zrle_scoreboard;
    logic [15:0] width = '0;
    logic [15:0] height = '0;
    logic [7:0]  zero_run = '0;
    logic [31:0] position = '0;
    logic [16:0] emitted = '0;
    byte_rec_t   expected_bytes[$];
    int          mismatches = 0;
    int          pixels_noted = 0;
    int          bytes_checked = 0;
    int          images_closed = 0;
    int          oversized_images = 0;

    function void write_register(logic [zrle_pkg::CFG_INDEX_W-1:0] index, logic [15:0] value);
        if (index == zrle_pkg::CFG_IMAGE_WIDTH)
        begin
            width = value;
        end
        else if (index == zrle_pkg::CFG_IMAGE_HEIGHT)
        begin
            height = value;
        end
    endfunction

    function void emit(logic [7:0] value);
        byte_rec_t rec;
        rec = '0;
        rec.out_byte = value;
        expected_bytes.insert(expected_bytes.size(), rec);
        if (emitted < zrle_pkg::SIZE_CAP)
        begin
            emitted++;
        end
    endfunction

    function void note_pixel(logic [7:0] px);
        logic [31:0] count;
        logic        last;
        int          before_count;
        byte_rec_t   rec;
        pixels_noted++;
        if (width == 0 || height == 0)
        begin
            return;
        end
        count = 32'(width) * 32'(height);
        before_count = expected_bytes.size();
        last = ((33'(position) + 33'd1) >= 33'(count)) || (position >= count);
        if (px != 8'd0)
        begin
            if (zero_run != 8'd0)
            begin
                emit(8'd0);
                emit(zero_run);
                zero_run = '0;
            end
            emit(px);
        end
        else
        begin
            zero_run++;
            if (zero_run >= zrle_pkg::RUN_LIMIT)
            begin
                emit(8'd0);
                emit(zrle_pkg::RUN_LIMIT);
                zero_run = '0;
            end
        end
        if (last && zero_run != 8'd0)
        begin
            emit(8'd0);
            emit(zero_run);
        end
        if (expected_bytes.size() > before_count)
        begin
            rec = expected_bytes.pop_back();
            rec.burst_end = 1'b1;
            if (last)
            begin
                rec.image_end = 1'b1;
                if (emitted >= zrle_pkg::SIZE_CAP)
                begin
                    rec.total_size = 16'hFFFF;
                    rec.size_overflow = 1'b1;
                    oversized_images++;
                end
                else
                begin
                    rec.total_size = emitted[15:0];
                end
            end
            expected_bytes.insert(expected_bytes.size(), rec);
        end
        if (last)
        begin
            images_closed++;
            position = '0;
            emitted = '0;
            zero_run = '0;
        end
        else
        begin
            position++;
        end
    endfunction

    function string describe(byte_rec_t rec);
        return $sformatf("byte %02h burst_end %0b image_end %0b total_size %0d size_overflow %0b",
                         rec.out_byte, rec.burst_end, rec.image_end, rec.total_size,
                         rec.size_overflow);
    endfunction

    function void check_byte(byte_rec_t got);
        byte_rec_t want;
        bytes_checked++;
        if (expected_bytes.size() == 0)
        begin
            if (mismatches < 10)
            begin
                $display("Output transfer %0d arrived with nothing outstanding: %s",
                         bytes_checked, describe(got));
            end
            mismatches++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got !== want)
        begin
            if (mismatches < 10)
            begin
                $display("Output transfer %0d differs: expected %s", bytes_checked, describe(want));
                $display("    got %s", describe(got));
            end
            mismatches++;
        end
    endfunction
endclass

module zero_run_length_encoder_test;

    localparam int SETTLE_CYCLES = 4 * zrle_pkg::QUEUE_DEPTH + 8;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_PIXELS = 120;
    localparam int LIMIT_CYCLES = 200000;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [zrle_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [zrle_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [7:0]                       pixel = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [7:0]                       out_byte;
    logic                             burst_end;
    logic                             image_end;
    logic [15:0]                      total_size;
    logic                             size_overflow;

    zrle_scoreboard sb = new;
    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    bit hold_request = 1'b0;
    int cycle_count = 0;
    int input_stall_cycles = 0;

    zero_run_length_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .burst_end     (burst_end),
        .image_end     (image_end),
        .total_size    (total_size),
        .size_overflow (size_overflow)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pixel <= px;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_pixel(px);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input logic [15:0] w, input logic [15:0] h);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= zrle_pkg::CFG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_index <= zrle_pkg::CFG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_register(zrle_pkg::CFG_IMAGE_WIDTH, w);
        sb.write_register(zrle_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_pattern(input int wanted, output int sent);
        int pick;
        int zeros;
        sent = 0;
        while (sent < wanted)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
            begin
                send_pixel(8'($urandom));
                sent++;
            end
            else if (pick <= 3)
            begin
                zeros = $urandom_range(1, 6);
                repeat (zeros) send_pixel(8'h00);
                sent += zeros;
            end
            else
            begin
                send_pixel(8'($urandom_range(1, 255)));
                sent++;
            end
        end
    endtask

    initial
    begin : stall_driver
        int stall_left;
        int go_left;
        int hold_left;
        stall_left = 0;
        go_left = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!receiver_idle)
            begin
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (go_left > 0)
            begin
                go_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                go_left = $urandom_range(0, 6);
                stall_left = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : byte_sink
        byte_rec_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.out_byte = out_byte;
                got.burst_end = burst_end;
                got.image_end = image_end;
                got.total_size = total_size;
                got.size_overflow = size_overflow;
                sb.check_byte(got);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
            if (in_valid && in_stall)
            begin
                input_stall_cycles++;
            end
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int random_pixels;
        int sent;
        int kind;
        int w;
        int h;
        bit first_phase;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With no image size set, pixels are dropped.
        send_pixel(8'hFF);
        send_pixel(8'h00);
        settle();
        set_size(16'd5, 16'd0);
        send_pixel(8'h12);
        settle();
        set_size(16'd0, 16'd7);
        send_pixel(8'h34);
        settle();

        // One-pixel images: every transfer closes an image.
        set_size(16'd1, 16'd1);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h01);
        settle();

        set_size(16'd4, 16'd2);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h80);
        send_pixel(8'h01);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h00);
        settle();

        // Shrinking the image below the current position ends it on the next pixel.
        set_size(16'hFFFF, 16'hFFFF);
        send_pixel(8'h7F);
        send_pixel(8'h00);
        send_pixel(8'h00);
        settle();
        set_size(16'd2, 16'd1);
        send_pixel(8'hAA);
        settle();
        set_size(16'd3, 16'd1);
        send_pixel(8'h55);
        settle();
        set_size(16'd2, 16'd1);
        send_pixel(8'h00);
        settle();

        random_pixels = 0;
        first_phase = 1'b1;
        while (random_pixels < RANDOM_PIXELS)
        begin
            kind = first_phase ? 5 : $urandom_range(0, 9);
            if (kind == 0)
            begin
                w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 9);
                h = (w == 0) ? $urandom_range(0, 9) : 0;
            end
            else if (kind == 1)
            begin
                w = 1;
                h = 1;
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
            end
            set_size(16'(w), 16'(h));
            sender_idle = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            if (first_phase)
            begin
                // The receiver holds off while the sender keeps offering pixels.
                sender_idle = 1'b0;
                hold_request = 1'b1;
                first_phase = 1'b0;
                send_pattern(40, sent);
                random_pixels += sent;
            end
            else if (w == 0 || h == 0)
            begin
                send_pixel(8'($urandom));
                send_pixel(8'($urandom));
            end
            else
            begin
                send_pattern($urandom_range(4, 30), sent);
                random_pixels += sent;
            end
            settle();
        end

        $display("Covered %0d pixel transfers and %0d byte transfers over %0d images, %0d too large.",
                 sb.pixels_noted, sb.bytes_checked, sb.images_closed, sb.oversized_images);
        $display("The output was held off once for %0d cycles; the input stalled %0d cycles in all.",
                 HOLD_CYCLES, input_stall_cycles);
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/zrle_pkg.sv
rtl/zrle_front.sv
rtl/zrle_queue.sv
rtl/zrle_back.sv
rtl/zero_run_length_encoder.sv
tb/zero_run_length_encoder_test.sv
